FILE: hdl/fdl_pkg.sv
// Package for the fractional delay line: default sizes and the depth of the
// result queue. Used by fractional_delay_line; depends on nothing else.
`default_nettype none

package fdl_pkg;

    // Default configuration of the delay line.
    localparam int FDL_MAX_DEPTH   = 4096;
    localparam int FDL_SAMPLE_BITS = 24;
    localparam int FDL_FRAC_BITS   = 16;

    // Result queue depth. It covers the pipeline latency so that a full rate
    // stream keeps flowing while the downstream side is ready.
    localparam int FDL_OUT_DEPTH = 8;

    // Rounds a bit count up to whole bytes.
    function automatic int fdl_bytes_bits(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage : fdl_pkg

`default_nettype wire

FILE: hdl/fractional_delay_line.sv
// Fractional delay line with linear interpolation, top level.
// Depends on fdl_pkg for default sizes and the result queue depth.
`default_nettype none

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   sample_in, delay_amount
// m_axis    out  m_axis_tvalid/m_axis_tready   sample_out
// cfg       in   cfg_wr_en                     buffer_length
//
// The block takes one beat per clock cycle while m_axis keeps up. A result enters
// the result queue once its accepted input beat has passed the input register, the
// memory read and the multiplier stage, and can leave as soon as it is in the queue.
// s_axis_tready drops while FDL_OUT_DEPTH beats are outstanding, until m_axis drains.
// After reset the length is MAX_DEPTH; entries not written since reset or the last
// buffer_length write read as zero through a fill mark, so no clearing pass runs.

module fractional_delay_line #(
    parameter int MAX_DEPTH   = fdl_pkg::FDL_MAX_DEPTH,
    parameter int SAMPLE_BITS = fdl_pkg::FDL_SAMPLE_BITS,
    parameter int FRAC_BITS   = fdl_pkg::FDL_FRAC_BITS
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    // Configuration: buffer_length.
    input  wire logic                                     cfg_wr_en,
    input  wire logic [$clog2(MAX_DEPTH):0]               cfg_wr_data,
    // Input stream. tdata, from bit 0 up: sample_in, delay_amount, zero pad.
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    input  wire logic [fdl_pkg::fdl_bytes_bits(SAMPLE_BITS + $clog2(MAX_DEPTH)
                                               + FRAC_BITS)-1:0] s_axis_tdata,
    // Output stream. tdata, from bit 0 up: sample_out, zero pad.
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    output logic [fdl_pkg::fdl_bytes_bits(SAMPLE_BITS)-1:0] m_axis_tdata
);
    import fdl_pkg::*;

    // Address width, length width, delay width and position width.
    localparam int AW    = $clog2(MAX_DEPTH);
    localparam int LW    = AW + 1;
    localparam int DW    = AW + FRAC_BITS;
    localparam int PW    = LW + FRAC_BITS;
    localparam int SW    = SAMPLE_BITS;
    localparam int PRW   = SW + FRAC_BITS + 2;
    localparam int OUT_W = fdl_bytes_bits(SW);
    localparam int QAW   = $clog2(FDL_OUT_DEPTH);
    localparam int QCW   = $clog2(FDL_OUT_DEPTH + 1);

    typedef logic [SW-1:0] sample_t;

    // Input fields.
    sample_t       in_sample;
    logic [DW-1:0] in_delay;
    assign in_sample = s_axis_tdata[SW-1:0];
    assign in_delay  = s_axis_tdata[SW +: DW];

    // Buffer length and write pointer. wrapped_reg says that every entry
    // below the length holds a sample written since the last clear.
    logic [LW-1:0] len_reg, len_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic          wrapped_reg, wrapped_next;

    // Credit counter for beats accepted but not yet delivered.
    logic [QCW-1:0] credit_reg, credit_next;

    logic in_fire, out_fire;
    assign s_axis_tready = (credit_reg < QCW'(FDL_OUT_DEPTH));
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Clamp a length write to the legal range.
    logic [LW-1:0] cfg_len;
    always_comb begin
        if (cfg_wr_data < LW'(2)) begin
            cfg_len = LW'(2);
        end else if (cfg_wr_data > LW'(MAX_DEPTH)) begin
            cfg_len = LW'(MAX_DEPTH);
        end else begin
            cfg_len = cfg_wr_data;
        end
    end

    // Full span in fixed point and the saturated delay.
    logic [PW-1:0] full_pos;
    logic [PW-1:0] dsat;
    assign full_pos = {len_reg, {FRAC_BITS{1'b0}}};
    assign dsat     = (PW'(in_delay) > full_pos) ? full_pos : PW'(in_delay);

    logic [LW-1:0] wp_inc;
    assign wp_inc = {1'b0, wp_reg} + LW'(1);

    always_comb begin
        len_next     = len_reg;
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (cfg_wr_en) begin
            // A length write also empties the line.
            len_next     = cfg_len;
            wp_next      = '0;
            wrapped_next = 1'b0;
        end else if (in_fire) begin
            if (wp_inc >= len_reg) begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end else begin
                wp_next = wp_inc[AW-1:0];
            end
        end
    end

    always_comb begin
        credit_next = credit_reg;
        unique case ({in_fire, out_fire})
            2'b10:   credit_next = credit_reg + QCW'(1);
            2'b01:   credit_next = credit_reg - QCW'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= LW'(MAX_DEPTH);
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            credit_reg  <= '0;
        end else begin
            len_reg     <= len_next;
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
            credit_reg  <= credit_next;
        end
    end

    // Stage 0: the accepted beat with its write slot and saturated delay.
    logic          s0_valid_reg;
    sample_t       s0_sample_reg;
    logic [PW-1:0] s0_dsat_reg;
    logic [AW-1:0] s0_wp_reg;
    logic          s0_wrapped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else begin
            s0_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s0_sample_reg  <= in_sample;
            s0_dsat_reg    <= dsat;
            s0_wp_reg      <= wp_reg;
            s0_wrapped_reg <= wrapped_reg;
        end
    end

    // Read position: write position minus delay, wrapped by the length.
    logic [PW-1:0] wpos;
    logic [PW:0]   pos_diff;
    logic [PW-1:0] pos_alt, pos;
    logic [AW-1:0] rd_idx0, rd_idx1;
    logic [LW-1:0] idx0_inc;
    logic [FRAC_BITS-1:0] rd_frac;
    logic          rd_ok0, rd_ok1;

    assign wpos     = {1'b0, s0_wp_reg, {FRAC_BITS{1'b0}}};
    assign pos_diff = {1'b0, wpos} - {1'b0, s0_dsat_reg};
    assign pos_alt  = wpos + full_pos - s0_dsat_reg;
    assign pos      = pos_diff[PW] ? pos_alt : pos_diff[PW-1:0];
    assign rd_idx0  = pos[FRAC_BITS +: AW];
    assign rd_frac  = pos[FRAC_BITS-1:0];
    assign idx0_inc = {1'b0, rd_idx0} + LW'(1);
    assign rd_idx1  = (idx0_inc >= len_reg) ? '0 : idx0_inc[AW-1:0];
    // An entry holds data only once written since the last clear.
    assign rd_ok0   = s0_wrapped_reg || (rd_idx0 < s0_wp_reg);
    assign rd_ok1   = s0_wrapped_reg || (rd_idx1 < s0_wp_reg);

    // Sample store. Both reads and the write of one beat happen at the same
    // edge, reads returning the old contents, so the next beat already sees
    // this beat's sample.
    sample_t sample_mem [MAX_DEPTH];
    sample_t rd0_reg, rd1_reg;

    always_ff @(posedge aclk) begin
        if (s0_valid_reg) begin
            rd0_reg              <= sample_mem[rd_idx0];
            rd1_reg              <= sample_mem[rd_idx1];
            sample_mem[s0_wp_reg] <= s0_sample_reg;
        end
    end

    // Stage 1: read data back, with the fraction and the valid marks.
    logic                 s1_valid_reg;
    logic [FRAC_BITS-1:0] s1_frac_reg;
    logic                 s1_ok0_reg, s1_ok1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s0_valid_reg) begin
            s1_frac_reg <= rd_frac;
            s1_ok0_reg  <= rd_ok0;
            s1_ok1_reg  <= rd_ok1;
        end
    end

    // Difference of the two taps times the fraction.
    logic signed [SW-1:0]      tap_a, tap_b;
    logic signed [SW:0]        tap_diff;
    logic signed [FRAC_BITS:0] frac_s;
    logic signed [PRW-1:0]     prod;

    assign tap_a    = s1_ok0_reg ? $signed(rd0_reg) : '0;
    assign tap_b    = s1_ok1_reg ? $signed(rd1_reg) : '0;
    assign tap_diff = (SW+1)'(tap_b) - (SW+1)'(tap_a);
    assign frac_s   = $signed({1'b0, s1_frac_reg});
    assign prod     = frac_s * tap_diff;

    // Stage 2: product and the base tap.
    logic                  s2_valid_reg;
    logic signed [PRW-1:0] s2_prod_reg;
    sample_t               s2_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_prod_reg <= prod;
            s2_a_reg    <= tap_a;
        end
    end

    // The arithmetic shift rounds toward minus infinity; the sum stays
    // between the two taps, so truncation loses nothing.
    logic signed [PRW-1:0] prod_shift;
    sample_t               result;
    assign prod_shift = s2_prod_reg >>> FRAC_BITS;
    assign result     = s2_a_reg + prod_shift[SW-1:0];

    // Result queue.
    sample_t        out_mem [FDL_OUT_DEPTH];
    logic [QAW-1:0] q_wr_reg, q_wr_next;
    logic [QAW-1:0] q_rd_reg, q_rd_next;
    logic [QCW-1:0] q_cnt_reg, q_cnt_next;

    assign m_axis_tvalid = (q_cnt_reg != '0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = OUT_W'(out_mem[q_rd_reg]);

    always_comb begin
        q_wr_next  = q_wr_reg;
        q_rd_next  = q_rd_reg;
        q_cnt_next = q_cnt_reg;
        if (s2_valid_reg) begin
            q_wr_next = (q_wr_reg == QAW'(FDL_OUT_DEPTH - 1)) ? '0 : q_wr_reg + QAW'(1);
        end
        if (out_fire) begin
            q_rd_next = (q_rd_reg == QAW'(FDL_OUT_DEPTH - 1)) ? '0 : q_rd_reg + QAW'(1);
        end
        unique case ({s2_valid_reg, out_fire})
            2'b10:   q_cnt_next = q_cnt_reg + QCW'(1);
            2'b01:   q_cnt_next = q_cnt_reg - QCW'(1);
            default: q_cnt_next = q_cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            q_wr_reg  <= q_wr_next;
            q_rd_reg  <= q_rd_next;
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            out_mem[q_wr_reg] <= result;
        end
    end

endmodule : fractional_delay_line

`default_nettype wire
